[rtl/ssort_pkg.sv]
// ----------------------------------------------------------------------------
// ssort_pkg: shared definitions for the row-major selection sort unit
// Table geometry, index widths and the command/status bundles that run
// between the sort controller and the sort datapath.
// ----------------------------------------------------------------------------
package ssort_pkg;

  // table geometry
  localparam int MAX_ROWS = 16;
  localparam int COLUMNS  = 3;
  localparam int CAPACITY = MAX_ROWS * COLUMNS;

  // element width and index widths
  localparam int DATA_W = 32;
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;         // input request accepted this cycle
    logic pass_start;   // read position i, set scan pointer to i+1
    logic pass_first;   // capture element i as current minimum, read i+1
    logic scan_step;    // compare returning element, read the next one
    logic swap_a;       // write current element i to the minimum's slot
    logic swap_b;       // write minimum to slot i, advance i
    logic out_init;     // reset output pointer
    logic out_read;     // read element at output pointer
    logic out_capture;  // load output register
    logic out_next;     // advance output pointer
    logic clear;        // table done: drop count and overflow flag
  } ssort_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic pass_done;    // no pass left: i is the last position
    logic scan_more;    // scan pointer still inside the table
    logic out_last;     // output pointer is on the last element
  } ssort_status_t;

endpackage

[rtl/ssort_dp.sv]
// ----------------------------------------------------------------------------
// ssort_dp: element store and sort datapath
// Holds the element memory (one write and one registered read port), the
// element count, the overflow flag, the pass/scan/output pointers, the
// running minimum and the output register.
// ----------------------------------------------------------------------------
module ssort_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ssort_pkg::ssort_cmd_t  cmd,
  input  ssort_pkg::data_t       in_element,
  input  logic                   in_last,
  output ssort_pkg::ssort_status_t st,
  output ssort_pkg::data_t       out_element,
  output logic                   out_last,
  output logic                   out_drop
);
  import ssort_pkg::*;

  // element store
  data_t mem [CAPACITY];

  cnt_t  count_r, count_nxt;
  logic  ovf_r, ovf_nxt;
  idx_t  i_r, i_nxt;
  cnt_t  k_r, k_nxt;
  idx_t  cmp_idx_r, cmp_idx_nxt;
  idx_t  best_idx_r, best_idx_nxt;
  data_t best_val_r, best_val_nxt;
  data_t cur_val_r, cur_val_nxt;
  idx_t  o_r, o_nxt;
  data_t rd_data_r;
  data_t out_data_r, out_data_nxt;
  logic  out_last_r, out_last_nxt;
  logic  out_drop_r, out_drop_nxt;

  logic  room;
  logic  rd_en;
  idx_t  rd_addr;
  logic  wr_en;
  idx_t  wr_addr;
  data_t wr_data;

  assign room = (count_r < cnt_t'(CAPACITY));

  // status for the controller
  assign st.pass_done = ((cnt_t'(i_r) + cnt_t'(1)) >= count_r);
  assign st.scan_more = (k_r < count_r);
  assign st.out_last  = ((cnt_t'(o_r) + cnt_t'(1)) == count_r);

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = i_r;
    wr_en   = 1'b0;
    wr_addr = count_r[IDX_W-1:0];
    wr_data = in_element;
    if (cmd.pass_start) begin
      rd_en   = 1'b1;
      rd_addr = i_r;
    end
    if (cmd.pass_first || (cmd.scan_step && st.scan_more)) begin
      rd_en   = 1'b1;
      rd_addr = k_r[IDX_W-1:0];
    end
    if (cmd.out_read) begin
      rd_en   = 1'b1;
      rd_addr = o_r;
    end
    if (cmd.load && room) begin
      wr_en = 1'b1;
    end
    if (cmd.swap_a) begin
      wr_en   = 1'b1;
      wr_addr = best_idx_r;
      wr_data = cur_val_r;
    end
    if (cmd.swap_b) begin
      wr_en   = 1'b1;
      wr_addr = i_r;
      wr_data = best_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // next-state of the datapath registers
  always_comb begin
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    i_nxt        = i_r;
    k_nxt        = k_r;
    cmp_idx_nxt  = cmp_idx_r;
    best_idx_nxt = best_idx_r;
    best_val_nxt = best_val_r;
    cur_val_nxt  = cur_val_r;
    o_nxt        = o_r;
    out_data_nxt = out_data_r;
    out_last_nxt = out_last_r;
    out_drop_nxt = out_drop_r;

    // loading
    if (cmd.load) begin
      if (room) begin
        count_nxt = count_r + cnt_t'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
      if (in_last) begin
        i_nxt = '0;
      end
    end

    // selection pass
    if (cmd.pass_start) begin
      k_nxt = cnt_t'(i_r) + cnt_t'(1);
    end
    if (cmd.pass_first) begin
      cur_val_nxt  = rd_data_r;
      best_val_nxt = rd_data_r;
      best_idx_nxt = i_r;
      cmp_idx_nxt  = k_r[IDX_W-1:0];
      k_nxt        = k_r + cnt_t'(1);
    end
    if (cmd.scan_step) begin
      if (rd_data_r < best_val_r) begin
        best_val_nxt = rd_data_r;
        best_idx_nxt = cmp_idx_r;
      end
      if (st.scan_more) begin
        cmp_idx_nxt = k_r[IDX_W-1:0];
        k_nxt       = k_r + cnt_t'(1);
      end
    end
    if (cmd.swap_b) begin
      i_nxt = i_r + idx_t'(1);
    end

    // output
    if (cmd.out_init) begin
      o_nxt = '0;
    end
    if (cmd.out_capture) begin
      out_data_nxt = rd_data_r;
      out_last_nxt = st.out_last;
      out_drop_nxt = ovf_r;
    end
    if (cmd.out_next) begin
      o_nxt = o_r + idx_t'(1);
    end
    if (cmd.clear) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end
  end

  // count and overflow flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // pointers, minimum and output register
  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    k_r        <= k_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_val_r <= best_val_nxt;
    cur_val_r  <= cur_val_nxt;
    o_r        <= o_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_drop_r <= out_drop_nxt;
  end

  assign out_element = out_data_r;
  assign out_last    = out_last_r;
  assign out_drop    = out_drop_r;

endmodule

[rtl/ssort_ctrl.sv]
// ----------------------------------------------------------------------------
// ssort_ctrl: sequencer for load, sort and output
// Loads elements until the last one, runs a selection pass for each position
// but the last through the datapath, then walks the sorted store out one
// request at a time.
// ----------------------------------------------------------------------------
module ssort_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  input  logic                     in_last,
  output logic                     in_tready,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  input  ssort_pkg::ssort_status_t st,
  output ssort_pkg::ssort_cmd_t    cmd
);
  import ssort_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD,
    S_PASS,
    S_FIRST,
    S_SCAN,
    S_SWAP_A,
    S_SWAP_B,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_WAIT
  } state_t;

  state_t state_r;
  logic   in_rdy_r;
  logic   out_vld_r;
  logic   in_acc;
  logic   out_acc;

  assign in_acc  = in_tvalid && in_rdy_r;
  assign out_acc = out_vld_r && out_tready;

  // state and handshake flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      in_rdy_r  <= 1'b1;
      out_vld_r <= 1'b0;
    end else begin
      case (state_r)
        S_LOAD: begin
          if (in_acc && in_last) begin
            state_r  <= S_PASS;
            in_rdy_r <= 1'b0;
          end
        end
        S_PASS: begin
          if (st.pass_done) begin
            state_r <= S_OUT_RD;
          end else begin
            state_r <= S_FIRST;
          end
        end
        S_FIRST: begin
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (!st.scan_more) begin
            state_r <= S_SWAP_A;
          end
        end
        S_SWAP_A: begin
          state_r <= S_SWAP_B;
        end
        S_SWAP_B: begin
          state_r <= S_PASS;
        end
        S_OUT_RD: begin
          state_r <= S_OUT_LD;
        end
        S_OUT_LD: begin
          state_r   <= S_OUT_WAIT;
          out_vld_r <= 1'b1;
        end
        S_OUT_WAIT: begin
          if (out_tready) begin
            out_vld_r <= 1'b0;
            if (st.out_last) begin
              state_r  <= S_LOAD;
              in_rdy_r <= 1'b1;
            end else begin
              state_r <= S_OUT_RD;
            end
          end
        end
        default: begin
          state_r   <= S_LOAD;
          in_rdy_r  <= 1'b1;
          out_vld_r <= 1'b0;
        end
      endcase
    end
  end

  // datapath commands
  always_comb begin
    cmd             = '0;
    cmd.load        = (state_r == S_LOAD) && in_acc;
    cmd.pass_start  = (state_r == S_PASS) && !st.pass_done;
    cmd.out_init    = (state_r == S_PASS) && st.pass_done;
    cmd.pass_first  = (state_r == S_FIRST);
    cmd.scan_step   = (state_r == S_SCAN);
    cmd.swap_a      = (state_r == S_SWAP_A);
    cmd.swap_b      = (state_r == S_SWAP_B);
    cmd.out_read    = (state_r == S_OUT_RD);
    cmd.out_capture = (state_r == S_OUT_LD);
    cmd.out_next    = (state_r == S_OUT_WAIT) && out_acc && !st.out_last;
    cmd.clear       = (state_r == S_OUT_WAIT) && out_acc && st.out_last;
  end

  assign in_tready  = in_rdy_r;
  assign out_tvalid = out_vld_r;

endmodule

[rtl/selection_sort_row_major_unit.sv]
// ----------------------------------------------------------------------------
// selection_sort_row_major_unit: collect, sort and replay a signed table
// Takes one signed 32-bit element per request in row-major order, stores up
// to 48 (16 rows of 3), and on the request marked tlast sorts the store
// ascending by selection sort and sends it out with the final element marked.
// Loading takes a new element on every accepted request. The sort is paced by
// the single registered read port of the element store (one compare per cycle
// in the scan, two writes per swap). Each result is read, loaded into the
// output register and held until the sink accepts it, then the next is read.
// No new input is taken from the last input request until the last result is
// accepted. Elements past the 48th are discarded and every result of that
// table carries the dropped flag in tuser.
// ----------------------------------------------------------------------------
module selection_sort_row_major_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] element
  input  logic        in_tlast,   // final_element
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sorted_element
  output logic        out_tlast,  // final_result
  output logic        out_tuser   // [0] dropped
);
  import ssort_pkg::*;

  ssort_cmd_t    cmd;
  ssort_status_t st;
  data_t         out_element;

  ssort_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_last    (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  ssort_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_element  (data_t'(in_tdata)),
    .in_last     (in_tlast),
    .st          (st),
    .out_element (out_element),
    .out_last    (out_tlast),
    .out_drop    (out_tuser)
  );

  assign out_tdata = 32'(out_element);

endmodule

[rtl/ssort_chk.sv]
// ----------------------------------------------------------------------------
// ssort_chk: port-level checks for the selection sort unit
// Watches the two stream channels for ordering between load, sort and
// output phases.
// ----------------------------------------------------------------------------
module ssort_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // no input is taken while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while result pending");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser)))
    else $error("stalled result changed");

  // last input request starts the sort: nothing in or out next cycle
  a_sort_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> (!in_tready && !out_tvalid))
    else $error("sort did not start after last input");

  // last result accepted reopens the input
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && !out_tvalid))
    else $error("input not reopened after last result");

endmodule

bind selection_sort_row_major_unit ssort_chk u_ssort_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for selection_sort_row_major_unit
// Streams tables of signed elements into the unit and checks that each
// table comes back in ascending order. The last result of a table carries
// tlast, and every result carries the dropped flag when the store
// overflowed. A scoreboard object keeps its own copy of the store and
// predicts every result. Directed tables come first, then random tables of
// random size and content. Both sides of the stream pause at random.
// ----------------------------------------------------------------------------
module tb;
  import ssort_pkg::*;

  localparam int RANDOM_ITEMS  = 200;
  localparam int IDLE_LIMIT    = 20000;
  localparam int SETTLE_CYCLES = 50;

  typedef struct {
    data_t sorted_element;
    logic  final_result;
    logic  dropped;
  } sorted_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the element store and queues the sorted results
  // --------------------------------------------------------------------------
  class sort_scoreboard;
    data_t          table_store[CAPACITY];
    int unsigned    stored_count;
    bit             overflowed;
    sorted_result_t sorted_q[$];
    int             errors;

    function new();
      stored_count = 0;
      overflowed   = 1'b0;
      errors       = 0;
    endfunction

    // accepted input request: store or drop, and sort on the last element
    function void note_request(data_t value, logic last);
      int unsigned    pos;
      int unsigned    scan;
      int unsigned    min_pos;
      data_t          held;
      sorted_result_t res;
      if (stored_count < CAPACITY) begin
        table_store[stored_count] = value;
        stored_count++;
      end else begin
        overflowed = 1'b1;
      end
      if (!last) return;
      // selection sort; first minimum wins on ties
      for (pos = 0; pos < stored_count; pos++) begin
        min_pos = pos;
        for (scan = pos + 1; scan < stored_count; scan++) begin
          if (table_store[scan] < table_store[min_pos]) min_pos = scan;
        end
        held                 = table_store[min_pos];
        table_store[min_pos] = table_store[pos];
        table_store[pos]     = held;
      end
      for (pos = 0; pos < stored_count; pos++) begin
        res.sorted_element = table_store[pos];
        res.final_result   = (pos + 1 == stored_count);
        res.dropped        = overflowed;
        sorted_q.push_back(res);
      end
      stored_count = 0;
      overflowed   = 1'b0;
    endfunction

    // accepted result: compare with the oldest expected one
    function void check_result(data_t value, logic last, logic drop);
      sorted_result_t exp_res;
      if (sorted_q.size() == 0) begin
        $error("unexpected result: sorted_element=%0d final_result=%0b dropped=%0b",
               value, last, drop);
        errors++;
        return;
      end
      exp_res = sorted_q.pop_front();
      if (value !== exp_res.sorted_element) begin
        $error("sorted_element: expected %0d, got %0d", exp_res.sorted_element, value);
        errors++;
      end
      if (last !== exp_res.final_result) begin
        $error("final_result: expected %0b, got %0b", exp_res.final_result, last);
        errors++;
      end
      if (drop !== exp_res.dropped) begin
        $error("dropped: expected %0b, got %0b", exp_res.dropped, drop);
        errors++;
      end
    endfunction

    function int pending();
      return sorted_q.size();
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  sort_scoreboard sb = new();
  int             idle_cycles = 0;
  bit             source_quiet = 1'b0;
  bit             sink_quiet = 1'b0;

  selection_sort_row_major_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // mostly short pauses, a few long ones
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_gap();
    if (source_quiet || $urandom_range(0, 2) != 0) return 0;
    return pick_pause();
  endfunction

  // full-range values, clustered small values for ties, and the extremes
  function automatic data_t pick_element();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return data_t'($urandom);
    if (r < 88) return data_t'($signed($urandom_range(0, 8)) - 4);
    case ($urandom_range(0, 3))
      0: return data_t'(32'h8000_0000);
      1: return data_t'(32'h7fff_ffff);
      2: return data_t'(0);
      default: return data_t'(-1);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one request per call, with an optional gap before it
  // --------------------------------------------------------------------------
  task automatic send_element(input data_t value, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_request(value, last);
  endtask

  task automatic send_table(input data_t values[$]);
    int k;
    for (k = 0; k < values.size(); k++) begin
      send_element(values[k], k == values.size() - 1);
    end
  endtask

  // hold the sender off until every pending result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: check each accepted result, stall at random
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    int phase_cycles;
    stall        = 0;
    phase_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        sb.check_result(data_t'(out_tdata), out_tlast, out_tuser);
      end
      phase_cycles++;
      if (phase_cycles == 150) begin
        phase_cycles = 0;
        sink_quiet   = ($urandom_range(0, 3) == 0);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        if (!sink_quiet && $urandom_range(0, 3) == 0) stall = pick_pause();
      end
    end
  end

  // watchdog: cycles in a row with no request accepted on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    data_t values[$];
    int    sent;
    int    table_num;
    int    size;
    int    r;
    int    k;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // extremes, ties and a partial last row
    values = '{data_t'(7), data_t'(32'h8000_0000), data_t'(32'h7fff_ffff),
               data_t'(0), data_t'(-1), data_t'(1), data_t'(32'h5555_5555),
               data_t'(32'haaaa_aaaa), data_t'(7), data_t'(-1)};
    send_table(values);
    // single element table
    values = '{data_t'(42)};
    send_table(values);
    // two equal elements
    values = '{data_t'(-5), data_t'(-5)};
    send_table(values);
    // two full rows in descending order
    values = '{data_t'(3), data_t'(2), data_t'(1), data_t'(0), data_t'(-1),
               data_t'(-2)};
    send_table(values);
    drain_results();

    // random tables; the first ones overflow the store and fill it exactly
    sent      = 0;
    table_num = 0;
    while (sent < RANDOM_ITEMS) begin
      if (table_num == 0) begin
        size = CAPACITY + 2;
      end else if (table_num == 1) begin
        size = CAPACITY;
      end else if (table_num == 2) begin
        size = CAPACITY + 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 80) size = $urandom_range(1, 12);
        else if (r < 92) size = $urandom_range(13, CAPACITY - 1);
        else size = $urandom_range(CAPACITY, CAPACITY + 3);
      end
      values = {};
      for (k = 0; k < size; k++) values.push_back(pick_element());
      source_quiet = ($urandom_range(0, 3) == 0);
      send_table(values);
      sent += size;
      table_num++;
      if ($urandom_range(0, 5) == 0) drain_results();
    end
    in_tvalid <= 1'b0;

    // wait for the last results, then a little longer for strays
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (sb.pending() != 0) $error("%0d expected results never arrived", sb.pending());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
